@@ design/rps_pkg.sv @@
// Shared types and constants for the rectifier pool supervisor.
package rps_pkg;

   // Operation codes carried on the request tuser
   localparam logic [1:0] OP_STATUS   = 2'd0;
   localparam logic [1:0] OP_TICK     = 2'd1;
   localparam logic [1:0] OP_SETPOINT = 2'd2;

   // Register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_STATUS_ID_BASE  = 2'd0;
   localparam logic [1:0] REG_TIMEOUT_TICKS   = 2'd1;
   localparam logic [1:0] REG_VOLTAGE_LIMIT   = 2'd2;
   localparam logic [1:0] REG_MODULE_CUR_LIM  = 2'd3;

   // Register reset values
   localparam logic [28:0] RST_STATUS_ID_BASE = 29'd0;
   localparam logic [15:0] RST_TIMEOUT_TICKS  = 16'd1000;
   localparam logic [15:0] RST_VOLTAGE_LIMIT  = 16'd10000;
   localparam logic [15:0] RST_MODULE_CUR_LIM = 16'd1000;

   // Saturation points
   localparam logic [15:0] AGE_MAX  = 16'hFFFF;
   localparam logic [3:0]  LIVE_MAX = 4'd15;
   localparam logic [19:0] SUM_MAX  = 20'hFFFFF;

   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 80;
   localparam int REQ_USER_W = 2;
   localparam int RSP_USER_W = 1;

   // Request word, first field in the highest bits
   typedef struct packed {
      logic [1:0]  pad;
      logic        enable;
      logic [15:0] target_current;
      logic [15:0] target_voltage;
      logic [7:0]  rx_byte4;
      logic [7:0]  rx_byte3;
      logic [7:0]  rx_byte2;
      logic [7:0]  rx_byte1;
      logic [7:0]  rx_byte0;
      logic [28:0] frame_id;
   } req_data_type;

   // Response word, first field in the highest bits
   typedef struct packed {
      logic [4:0]  pad;
      logic        healthy;
      logic        pool_fault;
      logic [19:0] sum_current;
      logic [15:0] peak_voltage;
      logic [3:0]  live_modules;
      logic        control_on;
      logic [15:0] set_current_share;
      logic [15:0] set_voltage;
   } rsp_data_type;

endpackage

@@ design/rectifier_pool_supervisor_top.sv @@
// Top level of the rectifier pool supervisor: register file, module table and sequencer.
//
//  channel  direction  handshake           payload
//  req      in         req_tvalid/tready   tdata: status, setpoint fields; tuser: operation
//  rsp      out        rsp_tvalid/tready   tdata: setpoint and pool aggregates; tuser: frame_valid
//  csr      in/out     psel/penable/pready four 32-bit registers at 0x0, 0x4, 0x8, 0xC
//
//  rsp_tvalid rises after the apply step, the sweep over the module table and the done step
//  for a status or tick word; a setpoint word adds the prep step and the bit-serial divider
//  over CMAX_W = 16 + clog2(MODULES) bits before done. req_tready is high only while
//  the sequencer idles and returns in the cycle the result is loaded.
//  Reset is synchronous: all modules start timed out, registers take their reset values.
//  A result held by a stalled rsp side does not block the next word; the sequencer waits
//  at its end only if the output register is still full.
module rectifier_pool_supervisor_top #(
   parameter int MODULES = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   // frame_id, rx_byte0..4, target_voltage, target_current, enable (lowest bit up)
   input  logic [rps_pkg::REQ_DATA_W-1:0]   req_tdata,
   // operation
   input  logic [rps_pkg::REQ_USER_W-1:0]   req_tuser,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // set_voltage, set_current_share, control_on, live_modules, peak_voltage,
   // sum_current, pool_fault, healthy (lowest bit up)
   output logic [rps_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // frame_valid
   output logic [rps_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [3:0]                       csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import rps_pkg::*;

   localparam int IDX_W  = (MODULES > 1) ? $clog2(MODULES) : 1;
   localparam int CNT_W  = $clog2(MODULES + 1);
   localparam int CMAX_W = 16 + $clog2(MODULES);

   typedef enum logic [2:0] {
      S_IDLE, S_APPLY, S_SWEEP, S_PREP, S_DIV, S_DONE
   } state_type;

   // ---------------- configuration registers ----------------
   logic [28:0] base_ff;
   logic [15:0] timeout_ff;
   logic [15:0] vlimit_ff;
   logic [15:0] climit_ff;
   logic        csr_wr;
   logic [1:0]  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Write the addressed register
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= RST_STATUS_ID_BASE;
         timeout_ff <= RST_TIMEOUT_TICKS;
         vlimit_ff  <= RST_VOLTAGE_LIMIT;
         climit_ff  <= RST_MODULE_CUR_LIM;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_STATUS_ID_BASE: base_ff    <= csr_pwdata[28:0];
            REG_TIMEOUT_TICKS:  timeout_ff <= csr_pwdata[15:0];
            REG_VOLTAGE_LIMIT:  vlimit_ff  <= csr_pwdata[15:0];
            REG_MODULE_CUR_LIM: climit_ff  <= csr_pwdata[15:0];
            default:            ;
         endcase
      end
   end

   // Return the addressed register
   always_comb begin
      case (csr_idx)
         REG_STATUS_ID_BASE: csr_prdata = {3'd0, base_ff};
         REG_TIMEOUT_TICKS:  csr_prdata = {16'd0, timeout_ff};
         REG_VOLTAGE_LIMIT:  csr_prdata = {16'd0, vlimit_ff};
         REG_MODULE_CUR_LIM: csr_prdata = {16'd0, climit_ff};
         default:            csr_prdata = '0;
      endcase
   end

   // ---------------- sequencer registers ----------------
   state_type            state_ff;
   req_data_type         item_ff;
   logic [1:0]           op_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [CNT_W-1:0]     live_ff;
   logic [15:0]          peak_ff;
   logic [CMAX_W-1:0]    sum_ff;
   logic                 fault_ff;
   logic [15:0]          share_ff;
   logic                 rsp_valid_ff;
   rsp_data_type         rsp_data_ff;
   logic                 rsp_user_ff;

   // ---------------- module table ----------------
   logic [15:0]          volt_ff  [MODULES];
   logic [15:0]          curr_ff  [MODULES];
   logic [15:0]          age_ff   [MODULES];
   logic                 ovr_ff   [MODULES];
   logic [MODULES-1:0]   lost_ff;

   // Decode the status frame identifier against the base
   logic                 id_above;
   logic [29:0]          id_off;
   logic                 id_hit;
   logic [IDX_W-1:0]     wr_idx;

   assign id_above = item_ff.frame_id > base_ff;
   assign id_off   = {1'b0, item_ff.frame_id} - {1'b0, base_ff} - 30'd1;
   assign id_hit   = id_above && (id_off < 30'(MODULES));
   assign wr_idx   = id_off[IDX_W-1:0];

   // Age and timeout of the entry under the sweep
   logic [15:0]          age_in;
   logic                 lost_in;
   logic                 lost_cur;
   logic                 is_tick;
   logic                 sweep_last;

   assign is_tick    = (op_ff == OP_TICK);
   assign age_in     = (age_ff[idx_ff] < AGE_MAX) ? age_ff[idx_ff] + 16'd1 : age_ff[idx_ff];
   assign lost_in    = lost_ff[idx_ff] | (age_in > timeout_ff);
   assign lost_cur   = is_tick ? lost_in : lost_ff[idx_ff];
   assign sweep_last = (idx_ff == IDX_W'(MODULES - 1));

   // Write a status frame in the apply step, write back ages in a tick sweep
   always_ff @(posedge clock) begin
      if (state_ff == S_APPLY && op_ff == OP_STATUS && id_hit) begin
         volt_ff[wr_idx] <= {item_ff.rx_byte0, item_ff.rx_byte1};
         curr_ff[wr_idx] <= {item_ff.rx_byte2, item_ff.rx_byte3};
         ovr_ff[wr_idx]  <= item_ff.rx_byte4[1];
         age_ff[wr_idx]  <= '0;
      end else if (state_ff == S_SWEEP && is_tick) begin
         age_ff[idx_ff]  <= age_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lost_ff <= '1;
      end else if (state_ff == S_APPLY && op_ff == OP_STATUS && id_hit) begin
         lost_ff[wr_idx] <= 1'b0;
      end else if (state_ff == S_SWEEP && is_tick) begin
         lost_ff[idx_ff] <= lost_in;
      end
   end

   // ---------------- setpoint arithmetic ----------------
   logic [CMAX_W-1:0]    cmax;
   logic [CMAX_W-1:0]    cur_clamp;
   logic [CNT_W-1:0]     divisor;
   logic                 div_start;
   logic                 div_done;
   logic [CMAX_W-1:0]    quotient;
   logic [15:0]          vset;
   logic [15:0]          share_in;
   logic [3:0]           live_sat;
   logic [19:0]          sum_sat;
   rsp_data_type         rsp_data_in;

   assign cmax      = CMAX_W'(32'(MODULES) * 32'(climit_ff));
   assign cur_clamp = (CMAX_W'(item_ff.target_current) > cmax) ?
                      cmax : CMAX_W'(item_ff.target_current);
   assign divisor   = (live_ff != '0) ? live_ff :
                      (item_ff.enable ? CNT_W'(MODULES) : CNT_W'(1));
   assign div_start = (state_ff == S_PREP);
   assign share_in  = (quotient > CMAX_W'(climit_ff)) ? climit_ff : quotient[15:0];
   assign vset      = (item_ff.target_voltage > vlimit_ff) ? vlimit_ff : item_ff.target_voltage;

   rps_div #(
      .DVD_W (CMAX_W),
      .DVS_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cur_clamp),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   // Assemble the result word
   always_comb begin
      live_sat = (32'(live_ff) > 32'(LIVE_MAX)) ? LIVE_MAX : 4'(live_ff);
      sum_sat  = (32'(sum_ff) > 32'(SUM_MAX)) ? SUM_MAX : 20'(sum_ff);
      rsp_data_in                   = '0;
      rsp_data_in.live_modules      = live_sat;
      rsp_data_in.peak_voltage      = peak_ff;
      rsp_data_in.sum_current       = sum_sat;
      rsp_data_in.pool_fault        = fault_ff;
      rsp_data_in.healthy           = (live_ff != '0) && !fault_ff;
      if (op_ff == OP_SETPOINT) begin
         rsp_data_in.control_on        = item_ff.enable;
         rsp_data_in.set_voltage       = item_ff.enable ? vset : 16'd0;
         rsp_data_in.set_current_share = item_ff.enable ? share_ff : 16'd0;
      end
   end

   // ---------------- sequencer and output register ----------------
   logic req_acc;
   logic rsp_free;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         // drop a delivered word unless the done step reloads the register
         if (rsp_valid_ff && rsp_tready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  item_ff  <= req_data_type'(req_tdata);
                  op_ff    <= req_tuser[1:0];
                  state_ff <= S_APPLY;
               end
            end
            S_APPLY: begin
               idx_ff   <= '0;
               live_ff  <= '0;
               peak_ff  <= '0;
               sum_ff   <= '0;
               fault_ff <= 1'b0;
               state_ff <= S_SWEEP;
            end
            S_SWEEP: begin
               // accumulate the live entries
               if (!lost_cur) begin
                  live_ff  <= live_ff + 1'b1;
                  sum_ff   <= sum_ff + CMAX_W'(curr_ff[idx_ff]);
                  fault_ff <= fault_ff | ovr_ff[idx_ff];
                  if (volt_ff[idx_ff] > peak_ff) begin
                     peak_ff <= volt_ff[idx_ff];
                  end
               end
               if (sweep_last) begin
                  state_ff <= (op_ff == OP_SETPOINT) ? S_PREP : S_DONE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_PREP: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_done) begin
                  share_ff <= share_in;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= rsp_data_in;
                  rsp_user_ff  <= (op_ff == OP_SETPOINT);
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

@@ design/rps_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
module rps_div #(
   parameter int DVD_W = 20,
   parameter int DVS_W = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] work_ff, work_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             done_ff;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             fits;

   // Shift one dividend bit into the remainder and try a subtract
   always_comb begin
      trial   = {rem_ff, work_ff[DVD_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      fits    = trial >= {1'b0, dvs_ff};
      rem_in  = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      work_in = {work_ff[DVD_W-2:0], fits};
   end

   // Load on start, then step until the count runs out
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         cnt_ff  <= CNT_W'(DVD_W);
         done_ff <= 1'b0;
      end else if (cnt_ff != '0) begin
         cnt_ff  <= cnt_ff - 1'b1;
         done_ff <= (cnt_ff == CNT_W'(1));
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         work_ff <= dividend;
         rem_ff  <= '0;
         dvs_ff  <= divisor;
      end else if (cnt_ff != '0) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = work_ff;

endmodule

@@ design/rps_checker.sv @@
// Port-level checker for the rectifier pool supervisor, bound to the top level.
module rps_port_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [rps_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [rps_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import rps_pkg::*;

   rsp_data_type rsp;
   assign rsp = rsp_data_type'(rsp_tdata);

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // A word is worked on through the apply, sweep and done states, so ready drops after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready stayed high after an accepted word");

   // Only a control frame carries setpoint fields
   a_no_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |->
         rsp.set_voltage == 16'd0 && rsp.set_current_share == 16'd0 && !rsp.control_on)
      else $error("setpoint fields set without a control frame");

   // An empty pool reports no aggregates and is not healthy
   a_empty_pool: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.live_modules == 4'd0 |->
         rsp.peak_voltage == 16'd0 && rsp.sum_current == 20'd0 && !rsp.pool_fault
         && !rsp.healthy)
      else $error("aggregates reported with no live module");

   // Health follows the live count and the fault flag
   a_health: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp.healthy == (rsp.live_modules != 4'd0 && !rsp.pool_fault))
      else $error("health flag disagrees with live count and fault");

endmodule

bind rectifier_pool_supervisor_top rps_port_checker u_rps_checker (.*);

@@ verif/rps_checker.sv @@
// Watches the request, result and register ports of the pool supervisor; predicts and compares.
`timescale 1ns / 1ps

module rps_checker #(
   parameter int MODULES = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [rps_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [rps_pkg::REQ_USER_W-1:0]   req_tuser,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [rps_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic [rps_pkg::RSP_USER_W-1:0]   rsp_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [3:0]                       csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   input  logic [31:0]                      csr_prdata,
   input  logic                             csr_pready,
   output int                               fail_count,
   output int                               in_flight,
   output int                               result_count,
   output int                               frame_count,
   output int                               stored_count
);
   import rps_pkg::*;

   // One awaited result: frame flag from tuser and the packed result word
   typedef struct packed {
      logic         frame;
      rsp_data_type word;
   } pool_report_type;

   // Shadow registers
   logic [28:0] id_base;
   logic [15:0] timeout_lim;
   logic [15:0] volt_lim;
   logic [15:0] cur_lim;

   // Shadow module table
   logic [15:0] mod_volt [MODULES];
   logic [15:0] mod_cur  [MODULES];
   logic [15:0] mod_age  [MODULES];
   logic        mod_on   [MODULES];
   logic        mod_ovp  [MODULES];
   logic        mod_lost [MODULES];

   pool_report_type awaited_reports[$];

   int fails   = 0;
   int queued  = 0;
   int results = 0;
   int frames  = 0;
   int stored  = 0;

   assign fail_count   = fails;
   assign in_flight    = queued;
   assign result_count = results;
   assign frame_count  = frames;
   assign stored_count = stored;

   // Count a mismatch and print one line for it
   task automatic flag_mismatch(input string what, input longint unsigned got,
                                input longint unsigned want);
      fails++;
      $display("%0t ns mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
   endtask

   // Apply one word to the shadow pool and work out the result it causes
   task automatic pool_step(input logic [1:0] op, input req_data_type d,
                            output pool_report_type r);
      logic [29:0] fid30;
      logic [29:0] lo30;
      int          idx;
      int          live;
      int          sum;
      int          div;
      int          quot;
      logic [19:0] cmax;
      logic [19:0] cur_req;
      logic [15:0] volt_req;
      logic [15:0] peak;
      logic        fault;

      r = '0;
      case (op)
         OP_STATUS: begin
            fid30 = {1'b0, d.frame_id};
            lo30  = {1'b0, id_base};
            if (fid30 > lo30 && fid30 <= lo30 + 30'(MODULES)) begin
               idx = int'(fid30 - lo30) - 1;
               mod_volt[idx] = {d.rx_byte0, d.rx_byte1};
               mod_cur[idx]  = {d.rx_byte2, d.rx_byte3};
               mod_on[idx]   = d.rx_byte4[0];
               mod_ovp[idx]  = d.rx_byte4[1];
               mod_lost[idx] = 1'b0;
               mod_age[idx]  = '0;
               stored++;
            end
         end
         OP_TICK: begin
            for (int i = 0; i < MODULES; i++) begin
               if (mod_age[i] != AGE_MAX)
                  mod_age[i] = mod_age[i] + 16'd1;
               if (mod_age[i] > timeout_lim)
                  mod_lost[i] = 1'b1;
            end
         end
         OP_SETPOINT: begin
            live = 0;
            for (int i = 0; i < MODULES; i++)
               if (!mod_lost[i])
                  live++;
            cmax     = 20'(cur_lim) * 20'(MODULES);
            cur_req  = 20'(d.target_current);
            volt_req = d.target_voltage;
            if (cur_req > cmax)
               cur_req = cmax;
            if (volt_req > volt_lim)
               volt_req = volt_lim;
            // empty pool: spread over the whole pool when on, one module when off
            div = (live != 0) ? live : (d.enable ? MODULES : 1);
            quot = int'(cur_req) / div;
            if (quot > int'(cur_lim))
               quot = int'(cur_lim);
            if (!d.enable) begin
               volt_req = '0;
               quot     = 0;
            end
            r.frame                  = 1'b1;
            r.word.set_voltage       = volt_req;
            r.word.set_current_share = 16'(quot);
            r.word.control_on        = d.enable;
         end
         default: begin
            // no operation: report the aggregates only
         end
      endcase

      // Aggregates after the update
      live  = 0;
      sum   = 0;
      peak  = '0;
      fault = 1'b0;
      for (int i = 0; i < MODULES; i++) begin
         if (!mod_lost[i]) begin
            live++;
            if (mod_volt[i] > peak)
               peak = mod_volt[i];
            sum += int'(mod_cur[i]);
            if (mod_ovp[i])
               fault = 1'b1;
         end
      end
      if (sum > int'(SUM_MAX))
         sum = int'(SUM_MAX);
      r.word.live_modules = (live > int'(LIVE_MAX)) ? LIVE_MAX : 4'(live);
      r.word.peak_voltage = peak;
      r.word.sum_current  = 20'(sum);
      r.word.pool_fault   = fault;
      r.word.healthy      = (live > 0) && !fault;
   endtask

   // Compare one accepted result with the oldest expectation
   task automatic check_report(input pool_report_type got, input pool_report_type want);
      if (got.frame !== want.frame)
         flag_mismatch("frame_valid", 64'(got.frame), 64'(want.frame));
      if (got.word.set_voltage !== want.word.set_voltage)
         flag_mismatch("set_voltage", 64'(got.word.set_voltage),
                       64'(want.word.set_voltage));
      if (got.word.set_current_share !== want.word.set_current_share)
         flag_mismatch("set_current_share", 64'(got.word.set_current_share),
                       64'(want.word.set_current_share));
      if (got.word.control_on !== want.word.control_on)
         flag_mismatch("control_on", 64'(got.word.control_on), 64'(want.word.control_on));
      if (got.word.live_modules !== want.word.live_modules)
         flag_mismatch("live_modules", 64'(got.word.live_modules),
                       64'(want.word.live_modules));
      if (got.word.peak_voltage !== want.word.peak_voltage)
         flag_mismatch("peak_voltage", 64'(got.word.peak_voltage),
                       64'(want.word.peak_voltage));
      if (got.word.sum_current !== want.word.sum_current)
         flag_mismatch("sum_current", 64'(got.word.sum_current),
                       64'(want.word.sum_current));
      if (got.word.pool_fault !== want.word.pool_fault)
         flag_mismatch("pool_fault", 64'(got.word.pool_fault), 64'(want.word.pool_fault));
      if (got.word.healthy !== want.word.healthy)
         flag_mismatch("healthy", 64'(got.word.healthy), 64'(want.word.healthy));
   endtask

   always @(posedge clock) begin
      pool_report_type got;
      pool_report_type want;
      logic [31:0]     reg_want;

      if (reset) begin
         // Hold the reset state of registers and table
         id_base     = RST_STATUS_ID_BASE;
         timeout_lim = RST_TIMEOUT_TICKS;
         volt_lim    = RST_VOLTAGE_LIMIT;
         cur_lim     = RST_MODULE_CUR_LIM;
         for (int i = 0; i < MODULES; i++) begin
            mod_volt[i] = '0;
            mod_cur[i]  = '0;
            mod_age[i]  = '0;
            mod_on[i]   = 1'b0;
            mod_ovp[i]  = 1'b0;
            mod_lost[i] = 1'b1;
         end
         awaited_reports.delete();
      end else begin
         // Results first: a word accepted at this edge cannot have its result yet
         if (rsp_tvalid && rsp_tready) begin
            results++;
            got.frame = rsp_tuser[0];
            got.word  = rsp_data_type'(rsp_tdata);
            if (awaited_reports.size() == 0) begin
               flag_mismatch("unexpected result word", 64'(rsp_tdata), 64'd0);
            end else begin
               want = awaited_reports.pop_front();
               if (want.frame)
                  frames++;
               check_report(got, want);
            end
         end

         // Predict the result of each accepted request word
         if (req_tvalid && req_tready) begin
            pool_step(req_tuser, req_data_type'(req_tdata), want);
            awaited_reports.push_back(want);
         end

         // Track register writes, check reads
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr[3:2])
                  REG_STATUS_ID_BASE: id_base     = csr_pwdata[28:0];
                  REG_TIMEOUT_TICKS:  timeout_lim = csr_pwdata[15:0];
                  REG_VOLTAGE_LIMIT:  volt_lim    = csr_pwdata[15:0];
                  REG_MODULE_CUR_LIM: cur_lim     = csr_pwdata[15:0];
                  default: ;
               endcase
            end else begin
               case (csr_paddr[3:2])
                  REG_STATUS_ID_BASE: reg_want = 32'(id_base);
                  REG_TIMEOUT_TICKS:  reg_want = 32'(timeout_lim);
                  REG_VOLTAGE_LIMIT:  reg_want = 32'(volt_lim);
                  default:            reg_want = 32'(cur_lim);
               endcase
               if (csr_prdata !== reg_want)
                  flag_mismatch("register read", 64'(csr_prdata), 64'(reg_want));
            end
         end
      end
      queued = awaited_reports.size();
   end

endmodule

@@ verif/tb_rectifier_pool_supervisor_top.sv @@
// Stimulus and verdict for the rectifier pool supervisor: clock, reset, words and registers.
`timescale 1ns / 1ps

module tb_rectifier_pool_supervisor_top;
   import rps_pkg::*;

   localparam int         POOL_SIZE     = 10;
   localparam int         SETTLE_CYCLES = 48;
   localparam int         PHASE_WORDS   = 186;
   localparam logic [1:0] OP_NONE       = 2'd3;

   logic                    clock;
   logic                    reset;
   logic [REQ_DATA_W-1:0]   req_tdata;
   logic [REQ_USER_W-1:0]   req_tuser;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [RSP_USER_W-1:0]   rsp_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [3:0]              csr_paddr;
   logic [31:0]             csr_pwdata;
   logic [31:0]             csr_prdata;
   logic                    csr_pready;

   int          fail_count;
   int          in_flight;
   int          result_count;
   int          frame_count;
   int          stored_count;
   int          words_sent = 0;
   logic        calm = 1'b0;
   logic [28:0] base_id = RST_STATUS_ID_BASE;

   rectifier_pool_supervisor_top #(.MODULES(POOL_SIZE)) dut (.*);

   rps_checker #(.MODULES(POOL_SIZE)) monitor (
      .clock, .reset,
      .req_tdata, .req_tuser, .req_tvalid, .req_tready,
      .rsp_tdata, .rsp_tuser, .rsp_tvalid, .rsp_tready,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_prdata,
      .csr_pready,
      .fail_count, .in_flight, .result_count, .frame_count, .stored_count
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Global limit
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Result side: stall at random unless in a calm stretch
   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(0, 99) >= 16);
   end

   // Send one word; idle at random first unless in a calm stretch
   task automatic send_item(input logic [1:0] op, input logic [28:0] fid,
                            input logic [39:0] rx, input logic [15:0] tv,
                            input logic [15:0] tc, input logic en);
      req_data_type w;

      w.pad            = '0;
      w.enable         = en;
      w.target_current = tc;
      w.target_voltage = tv;
      w.rx_byte0       = rx[39:32];
      w.rx_byte1       = rx[31:24];
      w.rx_byte2       = rx[23:16];
      w.rx_byte3       = rx[15:8];
      w.rx_byte4       = rx[7:0];
      w.frame_id       = fid;
      if (!calm) begin
         while ($urandom_range(0, 99) < 16) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
   endtask

   // Status frames, mostly for pool members, with random content, plus ticks, setpoints and noise
   task automatic send_random_item();
      int          pick;
      int          mode;
      logic [1:0]  op;
      logic [28:0] fid;
      logic [39:0] rx;
      logic [15:0] tv;
      logic [15:0] tc;
      logic        en;

      fid       = 29'($urandom);
      rx        = {$urandom, 8'($urandom)};
      rx[7:0]   = (8'($urandom) & 8'hFD) | (($urandom_range(0, 99) < 12) ? 8'h02 : 8'h00);
      tv        = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
      tc        = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
      en        = ($urandom_range(0, 99) < 80);
      pick      = $urandom_range(0, 99);
      if (pick < 45) begin
         op   = OP_STATUS;
         mode = $urandom_range(0, 99);
         if (mode < 85)
            fid = base_id + 29'($urandom_range(1, POOL_SIZE));
         else if (mode < 90)
            fid = base_id;
         else if (mode < 95)
            fid = base_id + 29'(POOL_SIZE + 1);
      end else if (pick < 70) begin
         op = OP_TICK;
      end else if (pick < 95) begin
         op = OP_SETPOINT;
      end else begin
         op = OP_NONE;
      end
      send_item(op, fid, rx, tv, tc, en);
   endtask

   // Drop valid and wait until every awaited result is in and the block is idle
   task automatic quiesce();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (in_flight != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register access: setup cycle, then access cycle until pready
   task automatic csr_access(input logic wr, input logic [1:0] idx, input logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_back();
      csr_access(1'b0, REG_STATUS_ID_BASE, '0);
      csr_access(1'b0, REG_TIMEOUT_TICKS, '0);
      csr_access(1'b0, REG_VOLTAGE_LIMIT, '0);
      csr_access(1'b0, REG_MODULE_CUR_LIM, '0);
   endtask

   // Write all four registers while idle, then read them back
   task automatic configure(input logic [28:0] id_base, input logic [15:0] ticks,
                            input logic [15:0] vlim, input logic [15:0] clim);
      quiesce();
      csr_access(1'b1, REG_STATUS_ID_BASE, 32'(id_base));
      csr_access(1'b1, REG_TIMEOUT_TICKS, 32'(ticks));
      csr_access(1'b1, REG_VOLTAGE_LIMIT, 32'(vlim));
      csr_access(1'b1, REG_MODULE_CUR_LIM, 32'(clim));
      read_back();
      base_id = id_base;
   endtask

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= OP_STATUS;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under reset register values
      read_back();
      send_item(OP_SETPOINT, '0, '0, 16'hFFFF, 16'hFFFF, 1'b1);     // empty pool, on
      send_item(OP_SETPOINT, '0, '0, 16'd500, 16'd500, 1'b0);       // empty pool, off
      send_item(OP_NONE, 29'($urandom), {$urandom, 8'($urandom)}, 16'($urandom),
                16'($urandom), 1'b1);
      send_item(OP_TICK, '0, '0, '0, '0, 1'b0);
      send_item(OP_STATUS, 29'd0, 40'h11_22_33_44_01, '0, '0, 1'b0);  // id equals base
      send_item(OP_STATUS, 29'(POOL_SIZE + 1), 40'h11_22_33_44_01, '0, '0, 1'b0);
      send_item(OP_STATUS, 29'h1FFFFFFF, 40'hFF_FF_FF_FF_03, '0, '0, 1'b0);
      send_item(OP_STATUS, 29'd1, 40'hFF_FF_FF_FF_FF, '0, '0, 1'b0); // first module, fault
      send_item(OP_STATUS, 29'(POOL_SIZE), 40'h00_00_00_00_00, '0, '0, 1'b0);
      send_item(OP_STATUS, 29'd5, 40'h12_34_00_64_01, '0, '0, 1'b0);
      send_item(OP_SETPOINT, '0, '0, 16'd0, 16'd0, 1'b1);
      send_item(OP_SETPOINT, '0, '0, 16'd12000, 16'd3001, 1'b1);
      send_item(OP_STATUS, 29'd1, 40'h27_10_03_E8_01, '0, '0, 1'b0); // clear the fault
      send_item(OP_SETPOINT, '0, '0, 16'd9999, 16'hFFFF, 1'b1);
      send_item(OP_STATUS, 29'd2, 40'hAB_CD_EF_01_FC, '0, '0, 1'b0);
      send_item(OP_TICK, 29'h1FFFFFFF, 40'hFF_FF_FF_FF_FF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_item(OP_TICK, '0, '0, '0, '0, 1'b0);
      send_item(OP_NONE, 29'h1FFFFFFF, 40'hFF_FF_FF_FF_FF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_item(OP_NONE, '0, '0, '0, '0, 1'b0);
      send_item(OP_SETPOINT, 29'h1FFFFFFF, 40'hFF_FF_FF_FF_FF, 16'hFFFF, 16'hFFFF, 1'b0);

      // Random part over several register settings
      for (int phase = 1; phase <= 5; phase++) begin
         case (phase)
            1: configure(29'h1FFFFFF5, 16'd3, 16'hFFFF, 16'hFFFF);
            2: configure(29'h1FFFFFFF, 16'd0, 16'd0, 16'd0);
            3: configure(29'd100, 16'hFFFF, 16'd1234, 16'd7);
            4: configure(29'd5, 16'd1, 16'd10000, 16'd1000);
            default: configure(29'($urandom_range(0, 29'h1FFFFFF5)),
                               16'($urandom_range(2, 40)), 16'($urandom),
                               16'($urandom_range(0, 3000)));
         endcase
         calm = (phase == 3);
         for (int i = 0; i < PHASE_WORDS; i++) begin
            if (i == 60)
               quiesce();
            send_random_item();
         end
      end

      calm = 1'b0;
      quiesce();
      $display("Summary: %0d request words, %0d results checked, %0d control frames,",
               words_sent, result_count, frame_count);
      $display("Summary: %0d frames stored; reset values and five register settings",
               stored_count);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
